>>> rtl/rsrg_pkg.sv
`default_nettype none
package rsrg_pkg;

    localparam int KEY_W       = 32;
    localparam int HSIZE_W     = 6;
    localparam int MAX_ENTRIES = 32;
    localparam int HSIZE_RESET = 32;

    // Input item: op = 0 carries a key, op = 1 ends the input and drains.
    typedef struct packed {
        logic                    op;
        logic signed [KEY_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] value_res;
        logic                    run_start;
        logic                    last;
    } t_out_item;

    // One heap entry: run mark and key.
    typedef struct packed {
        logic             mark;
        logic [KEY_W-1:0] key;
    } t_entry;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RM_RD0,
        S_RM_RDL,
        S_RM_LAST,
        S_RM_CHK,
        S_RM_RC1,
        S_RM_RC2,
        S_RM_PLACE,
        S_IN_START,
        S_IN_CHK,
        S_IN_CMP,
        S_IN_PLACE
    } t_state;

    // True when entry a orders strictly before entry b. Entries of the
    // current run come first; within a class the smaller signed key wins.
    function automatic logic entry_before(t_entry a, t_entry b, logic cur);
        logic ca;
        logic cb;
        ca = (a.mark != cur);
        cb = (b.mark != cur);
        if (ca != cb) begin
            return !ca;
        end
        return $signed(a.key) < $signed(b.key);
    endfunction

endpackage
`default_nettype wire

>>> rtl/rsrg_heap_mem.sv
`default_nettype none
module rsrg_heap_mem
    import rsrg_pkg::*;
#(
    parameter int DEPTH = MAX_ENTRIES,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/rsrg_seq.sv
`default_nettype none
module rsrg_seq
    import rsrg_pkg::*;
#(
    parameter int MAX_N = MAX_ENTRIES,
    localparam int AW   = (MAX_N > 1) ? $clog2(MAX_N) : 1,
    localparam int CNTW = $clog2(MAX_N + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [HSIZE_W-1:0] i_cfg_data,
    output logic                    o_mem_we,
    output logic [AW-1:0]           o_mem_waddr,
    output t_entry                  o_mem_wdata,
    output logic [AW-1:0]           o_mem_raddr,
    input  wire t_entry             i_mem_rdata
);

    localparam int EW = (CNTW > HSIZE_W) ? CNTW : HSIZE_W;
    localparam int IW = AW + 2;

    t_state r_state, n_state;
    logic [CNTW-1:0]    r_cnt, n_cnt;
    logic               r_cur, n_cur;
    logic               r_any, n_any;
    logic               r_flush, n_flush;
    logic [HSIZE_W-1:0] r_hsize;
    logic [KEY_W-1:0]   r_val, n_val;
    logic               r_nmark, n_nmark;
    logic [AW-1:0]      r_i, n_i;
    t_entry             r_left, n_left;
    t_entry             r_k, n_k;
    t_entry             r_root, n_root;
    logic               r_oval, n_oval;
    t_out_item          r_oitem, n_oitem;

    logic [EW-1:0] eff;
    logic [EW-1:0] cnt_ext;
    logic [IW-1:0] c_idx;
    logic [IW-1:0] c1_idx;
    logic [IW-1:0] cnt_i;
    logic          c_out;
    logic          c1_in;
    logic [AW-1:0] p_idx;
    logic          out_free;
    logic          right_win;
    t_entry        child;
    logic [AW-1:0] child_idx;
    logic          child_up;
    logic          new_up;
    logic          start_bit;
    t_entry        new_entry;

    // Effective heap size: zero acts as one, too large is clamped.
    always_comb begin
        if (r_hsize == '0) begin
            eff = EW'(1);
        end else if (EW'(r_hsize) > EW'(MAX_N)) begin
            eff = EW'(MAX_N);
        end else begin
            eff = EW'(r_hsize);
        end
    end

    // Child and parent indexes.
    assign cnt_ext   = EW'(r_cnt);
    assign cnt_i     = IW'(r_cnt);
    assign c_idx     = {1'b0, r_i, 1'b1};
    assign c1_idx    = c_idx + IW'(1);
    assign c_out     = (c_idx >= cnt_i);
    assign c1_in     = (c1_idx < cnt_i);
    assign p_idx     = AW'((IW'(r_i) - IW'(1)) >> 1);
    assign out_free  = !r_oval || i_out_ready;
    assign right_win = c1_in && entry_before(i_mem_rdata, r_left, r_cur);
    assign child     = right_win ? i_mem_rdata : r_left;
    assign child_idx = right_win ? c1_idx[AW-1:0] : c_idx[AW-1:0];
    assign child_up  = entry_before(child, r_k, r_cur);
    assign new_entry = '{mark: r_nmark, key: r_val};
    assign new_up    = entry_before(new_entry, i_mem_rdata, r_cur);
    assign start_bit = !r_any || (r_root.mark != r_cur);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_item.op == OP_FLUSH) begin
                        n_state = (r_cnt == '0) ? S_IDLE : S_RM_RD0;
                    end else if (cnt_ext < eff) begin
                        n_state = S_IN_START;
                    end else begin
                        n_state = S_RM_RD0;
                    end
                end
            end
            S_RM_RD0:  n_state = S_RM_RDL;
            S_RM_RDL:  n_state = S_RM_LAST;
            S_RM_LAST: n_state = S_RM_CHK;
            S_RM_CHK:  n_state = c_out ? S_RM_PLACE : S_RM_RC1;
            S_RM_RC1:  n_state = S_RM_RC2;
            S_RM_RC2:  n_state = child_up ? S_RM_CHK : S_RM_PLACE;
            S_RM_PLACE: begin
                if (out_free) begin
                    if (r_flush) begin
                        n_state = (r_cnt == '0) ? S_IDLE : S_RM_RD0;
                    end else begin
                        n_state = S_IN_START;
                    end
                end
            end
            S_IN_START: n_state = S_IN_CHK;
            S_IN_CHK:   n_state = (r_i == '0) ? S_IN_PLACE : S_IN_CMP;
            S_IN_CMP:   n_state = new_up ? S_IN_CHK : S_IN_PLACE;
            S_IN_PLACE: n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath, memory control and result register.
    always_comb begin
        n_cnt       = r_cnt;
        n_cur       = r_cur;
        n_any       = r_any;
        n_flush     = r_flush;
        n_val       = r_val;
        n_nmark     = r_nmark;
        n_i         = r_i;
        n_left      = r_left;
        n_k         = r_k;
        n_root      = r_root;
        n_oval      = r_oval && !i_out_ready;
        n_oitem     = r_oitem;
        o_in_ready  = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_i;
        o_mem_wdata = new_entry;
        o_mem_raddr = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_val   = i_in_item.value;
                    n_nmark = r_cur;
                    n_flush = (i_in_item.op == OP_FLUSH);
                    if (i_in_item.op == OP_FLUSH && r_cnt == '0) begin
                        n_cur = 1'b0;
                        n_any = 1'b0;
                    end
                end
            end
            S_RM_RD0: begin
                o_mem_raddr = '0;
                n_cnt       = r_cnt - CNTW'(1);
            end
            S_RM_RDL: begin
                o_mem_raddr = AW'(r_cnt);
                n_root      = i_mem_rdata;
            end
            S_RM_LAST: begin
                n_k = i_mem_rdata;
                n_i = '0;
            end
            S_RM_CHK: begin
                o_mem_raddr = c_idx[AW-1:0];
            end
            S_RM_RC1: begin
                o_mem_raddr = c1_idx[AW-1:0];
                n_left      = i_mem_rdata;
            end
            S_RM_RC2: begin
                if (child_up) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_i;
                    o_mem_wdata = child;
                    n_i         = child_idx;
                end
            end
            S_RM_PLACE: begin
                o_mem_we    = (r_cnt != '0);
                o_mem_waddr = r_i;
                o_mem_wdata = r_k;
                if (out_free) begin
                    n_oval            = 1'b1;
                    n_oitem.value_res = r_root.key;
                    n_oitem.run_start = start_bit;
                    n_oitem.last      = r_flush && (r_cnt == '0);
                    if (r_flush && r_cnt == '0) begin
                        n_cur = 1'b0;
                        n_any = 1'b0;
                    end else begin
                        n_cur = r_root.mark;
                        n_any = 1'b1;
                    end
                    if ($signed(r_val) < $signed(r_root.key)) begin
                        n_nmark = !r_root.mark;
                    end else begin
                        n_nmark = r_root.mark;
                    end
                end
            end
            S_IN_START: begin
                n_i   = AW'(r_cnt);
                n_cnt = r_cnt + CNTW'(1);
            end
            S_IN_CHK: begin
                o_mem_raddr = p_idx;
            end
            S_IN_CMP: begin
                if (new_up) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_i;
                    o_mem_wdata = i_mem_rdata;
                    n_i         = p_idx;
                end
            end
            S_IN_PLACE: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_i;
                o_mem_wdata = new_entry;
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_cur   <= 1'b0;
            r_any   <= 1'b0;
            r_flush <= 1'b0;
            r_oval  <= 1'b0;
            r_hsize <= HSIZE_W'(HSIZE_RESET);
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_cur   <= n_cur;
            r_any   <= n_any;
            r_flush <= n_flush;
            r_oval  <= n_oval;
            if (i_cfg_we) begin
                r_hsize <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_nmark <= n_nmark;
        r_i     <= n_i;
        r_left  <= n_left;
        r_k     <= n_k;
        r_root  <= n_root;
        r_oitem <= n_oitem;
    end

    assign o_out_valid = r_oval;
    assign o_out_item  = r_oitem;

    // The fill count never passes the heap depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNTW'(MAX_N) >= r_cnt)
        else $error("heap count exceeds depth");

    // A removal only starts on a heap that holds something.
    a_rm_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && r_cnt == '0) |=> (r_state != S_RM_RD0))
        else $error("removal started on empty heap");

    // The final drained key returns run tracking to its start values.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RM_PLACE && out_free && r_flush && r_cnt == '0)
        |=> (!r_any && !r_cur && r_state == S_IDLE))
        else $error("drain end did not clear run state");

    // The memory is never written while waiting for input.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_mem_we)
        else $error("heap write while idle");

endmodule
`default_nettype wire

>>> rtl/replacement_selection_run_generator_unit.sv
`default_nettype none
// Replacement-selection run generator. Keys enter as transfers with op = 0;
// until heap_size keys are held nothing comes out, and after that each key
// pops the smallest key of the current run as one result transfer, with
// run_start set where a new run begins. A transfer with op = 1 drains the
// heap in order, flags the final key with last, and starts a new sort. The
// heap lives in one single-port-write, registered-read memory that a
// sequencer walks one level at a time; no new transfer is taken until the
// previous one is done. heap_size is written through i_cfg_we and i_cfg_data;
// the user must write it only while the block is idle, as the block itself
// does not enforce this. Zero acts as one.
module replacement_selection_run_generator_unit
    import rsrg_pkg::*;
#(
    parameter int MAX_N = MAX_ENTRIES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [HSIZE_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;

    // Heap store.
    rsrg_heap_mem #(
        .DEPTH(MAX_N)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // Heap sequencer and result register.
    rsrg_seq #(
        .MAX_N(MAX_N)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_mem_we   (mem_we),
        .o_mem_waddr(mem_waddr),
        .o_mem_wdata(mem_wdata),
        .o_mem_raddr(mem_raddr),
        .i_mem_rdata(mem_rdata)
    );

endmodule
`default_nettype wire

>>> tb/sv/replacement_selection_run_generator_unit_test.sv
`default_nettype none
module replacement_selection_run_generator_unit_test;
    import rsrg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 20000;

    // Scoreboard: a flat model of the heap and the run bookkeeping.
    class run_sorter_board;
        t_entry    entries[$];
        t_out_item emitted_keys[$];
        logic      run_mark;
        logic      any_out;
        logic [HSIZE_W-1:0] heap_limit;
        int        mismatches;
        int        results_seen;

        function void clear();
            entries.delete();
            emitted_keys.delete();
            run_mark     = 1'b0;
            any_out      = 1'b0;
            heap_limit   = HSIZE_W'(HSIZE_RESET);
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_limit(logic [HSIZE_W-1:0] v);
            heap_limit = v;
        endfunction

        function int pending();
            return emitted_keys.size();
        endfunction

        // Current-run entries order first, then smaller signed key.
        function bit orders_first(t_entry a, t_entry b);
            bit ca;
            bit cb;
            ca = (a.mark != run_mark);
            cb = (b.mark != run_mark);
            if (ca != cb) begin
                return cb;
            end
            return $signed(a.key) < $signed(b.key);
        endfunction

        // Removes the minimum entry and queues it as an expected transfer.
        function logic [KEY_W-1:0] pop_smallest(logic is_last);
            int        best;
            t_entry    e;
            t_out_item r;
            best = 0;
            for (int i = 1; i < entries.size(); i++) begin
                if (orders_first(entries[i], entries[best])) begin
                    best = i;
                end
            end
            e = entries[best];
            entries.delete(best);
            r.value_res = e.key;
            r.run_start = !any_out || (e.mark != run_mark);
            r.last      = is_last;
            run_mark    = e.mark;
            any_out     = 1'b1;
            emitted_keys.push_back(r);
            return e.key;
        endfunction

        function void note_input(t_in_item it);
            int         eff;
            logic [KEY_W-1:0] popped;
            t_entry     e;
            eff = (heap_limit == 0) ? 1 : (heap_limit > MAX_ENTRIES) ? MAX_ENTRIES : heap_limit;
            if (it.op == OP_FLUSH) begin
                while (entries.size() > 0) begin
                    popped = pop_smallest(entries.size() == 1);
                end
                run_mark = 1'b0;
                any_out  = 1'b0;
            end else if (entries.size() < eff) begin
                e.mark = run_mark;
                e.key  = it.value;
                entries.push_back(e);
            end else begin
                popped = pop_smallest(1'b0);
                e.key  = it.value;
                e.mark = ($signed(it.value) < $signed(popped)) ? ~run_mark : run_mark;
                entries.push_back(e);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (emitted_keys.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: value %0d run_start %0b last %0b",
                             got.value_res, got.run_start, got.last);
                end
                return;
            end
            want = emitted_keys.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected value %0d run_start %0b last %0b, got %0d %0b %0b",
                             want.value_res, want.run_start, want.last,
                             got.value_res, got.run_start, got.last);
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in_item;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out_item;
    logic               i_cfg_we;
    logic [HSIZE_W-1:0] i_cfg_data;

    run_sorter_board board;
    int  idle_mode;
    int  items_sent;
    int  settings_used;
    int  quiet_cycles = 0;

    replacement_selection_run_generator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    // Result side: check each transfer and pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result(o_out_item);
        end
        if (idle_mode == 2) begin
            i_out_ready <= ($urandom_range(99) >= 70);
        end else if (idle_mode == 3) begin
            i_out_ready <= ($urandom_range(99) >= 9);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // One input transfer, with random sender gaps ahead of it.
    task automatic send_item(input logic op, input logic [KEY_W-1:0] v);
        t_in_item it;
        int       gap_pct;
        it.op    = op;
        it.value = v;
        gap_pct  = (idle_mode == 1) ? 70 : (idle_mode == 3) ? 9 : 0;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        board.note_input(it);
        items_sent++;
    endtask

    // Wait until no expected result is outstanding, then write the heap size.
    task automatic write_heap_size(input logic [HSIZE_W-1:0] v);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (HOLD_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_limit(v);
        settings_used++;
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        case ($urandom_range(3))
            0: return $urandom_range(7);
            1: return $urandom_range(7) - 4;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int sizes[10];
        int n;
        board         = new();
        board.clear();
        idle_mode     = 0;
        items_sent    = 0;
        settings_used = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: flush on an empty heap, extreme keys, a tiny heap.
        send_item(OP_FLUSH, 32'h0);
        write_heap_size(6'd2);
        send_item(OP_DATA, 32'h8000_0000);
        send_item(OP_DATA, 32'h7FFF_FFFF);
        send_item(OP_DATA, 32'hFFFF_FFFF);
        send_item(OP_DATA, 32'h0000_0000);
        send_item(OP_DATA, 32'h8000_0000);
        send_item(OP_DATA, 32'h0000_0005);
        send_item(OP_DATA, 32'h0000_0005);
        send_item(OP_FLUSH, 32'hFFFF_FFFF);
        write_heap_size(6'd0);
        send_item(OP_DATA, 32'h0000_0003);
        send_item(OP_DATA, 32'h0000_0001);
        send_item(OP_DATA, 32'h0000_0002);
        send_item(OP_FLUSH, 32'h0);
        // Partly fill a large heap, then shrink it below the number of keys it holds.
        write_heap_size(6'd63);
        for (int i = 0; i < 6; i++) begin
            send_item(OP_DATA, 32'd10 - i);
        end
        write_heap_size(6'd3);
        send_item(OP_DATA, 32'd1);
        send_item(OP_DATA, 32'd20);
        send_item(OP_FLUSH, 32'h0);

        // Random phases over several heap sizes and idling modes.
        sizes = '{32, 1, 5, 63, 2, 17, 0, 8, 33, 3};
        for (int ph = 0; items_sent < 300; ph++) begin
            idle_mode = ph % 4;
            write_heap_size(HSIZE_W'((ph < 10) ? sizes[ph] : $urandom_range(63)));
            n = $urandom_range(4, 45);
            for (int i = 0; i < n; i++) begin
                send_item(OP_DATA, random_key());
            end
            if ($urandom_range(3) != 0) begin
                send_item(OP_FLUSH, $urandom);
            end
        end
        send_item(OP_FLUSH, $urandom);
        i_in_valid <= 1'b0;

        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (HOLD_CYCLES) @(posedge i_clk);
        $display("Sent %0d items under %0d heap sizes and four idling modes; %0d keys checked.",
                 items_sent, settings_used, board.results_seen);
        if (board.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches in total.", board.mismatches);
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
